[sv/cwr_pkg.sv]
// ----------------------------------------------------------------------------
// cwr_pkg
// Shared types, constants and the cosine weight table builder for the
// warm-restart cosine learning-rate block.
// ----------------------------------------------------------------------------
package cwr_pkg;

	localparam int STEP_BITS       = 32;
	localparam int RATE_W          = 32;
	localparam int MULT_W          = 5;
	localparam int COS_TABLE_DEPTH = 1024;
	localparam int IDX_W           = $clog2(COS_TABLE_DEPTH);
	localparam int CNT_W           = $clog2(STEP_BITS);
	localparam int WEIGHT_W        = 31;
	localparam int FRAC_SHIFT      = 30;
	localparam int CFG_IDX_W       = 2;

	localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_PERIOD       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MULTIPLIER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_RATE         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_RATE        = 2'd3;

	localparam logic [STEP_BITS-1:0] BASE_PERIOD_RESET       = 32'd1000;
	localparam logic [MULT_W-1:0]    PERIOD_MULTIPLIER_RESET = 5'd1;
	localparam logic [RATE_W-1:0]    PEAK_RATE_RESET         = 32'd26843545;
	localparam logic [RATE_W-1:0]    FLOOR_RATE_RESET        = 32'd0;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic grow_step;
		logic pos_load;
		logic frac_step;
		logic rom_read;
		logic mul;
		logic finish;
	} cwr_cmd_t;

	typedef struct packed {
		logic mult_is_one;
		logic grow_more;
	} cwr_stat_t;

	// Table entry (1 + cos(pi * p / depth)) / 2 in Q1.30, evaluated as the
	// square of cos(theta) with theta = pi/2 * p / depth.
	function automatic logic [WEIGHT_W-1:0] rom_weight(input int unsigned p);
		longint unsigned theta;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned u;
		longint unsigned c;
		longint unsigned w;
		theta = (HALF_PI_Q30 * longint'(p)) / COS_TABLE_DEPTH;
		x2 = (theta * theta) >> 30;
		t = Q30_ONE;
		t = Q30_ONE - (((x2 * t) >> 30) / 182);
		t = Q30_ONE - (((x2 * t) >> 30) / 132);
		t = Q30_ONE - (((x2 * t) >> 30) / 90);
		t = Q30_ONE - (((x2 * t) >> 30) / 56);
		t = Q30_ONE - (((x2 * t) >> 30) / 30);
		t = Q30_ONE - (((x2 * t) >> 30) / 12);
		u = (x2 * t) >> 31;
		c = (u >= Q30_ONE) ? 64'd0 : Q30_ONE - u;
		w = (c * c) >> 30;
		return w[WEIGHT_W-1:0];
	endfunction

endpackage

[sv/cwr_datapath.sv]
// ----------------------------------------------------------------------------
// cwr_datapath
// Period search, shared restoring divide step, weight table and rate
// interpolation registers.
// ----------------------------------------------------------------------------
module cwr_datapath
	import cwr_pkg::*;
(
	input  logic                 clk,
	input  cwr_cmd_t             cmd,
	output cwr_stat_t            stat,
	input  logic [STEP_BITS-1:0] step_index,
	input  logic [STEP_BITS-1:0] base_period,
	input  logic [MULT_W-1:0]    period_multiplier,
	input  logic [RATE_W-1:0]    peak_rate,
	input  logic [RATE_W-1:0]    floor_rate,
	output logic [RATE_W-1:0]    rate
);

	logic [STEP_BITS-1:0] step_q;
	logic [STEP_BITS-1:0] period_q;
	logic [STEP_BITS-1:0] cum_q;
	logic [MULT_W-1:0]    mult_q;
	logic [STEP_BITS-1:0] rem_q;
	logic [IDX_W-1:0]     quot_q;
	logic [WEIGHT_W-1:0]  weight_q;
	logic [RATE_W-1:0]    diff_q;
	logic                 down_q;
	logic [RATE_W-1:0]    scaled_q;
	logic [RATE_W-1:0]    rate_q;

	logic [WEIGHT_W-1:0]       weight_rom [COS_TABLE_DEPTH];
	logic [STEP_BITS-1:0]      left;
	logic                      shift_bit;
	logic [STEP_BITS:0]        trial;
	logic                      fits;
	logic [STEP_BITS-1:0]      next_rem;
	logic [STEP_BITS+MULT_W-1:0] grown;
	logic [STEP_BITS-1:0]      next_period;
	logic [2*RATE_W-2:0]       product;

	for (genvar gi = 0; gi < COS_TABLE_DEPTH; gi++) begin : g_rom
		assign weight_rom[gi] = rom_weight(gi);
	end

	assign left      = step_q - cum_q;
	assign shift_bit = cmd.mod_step ? step_q[STEP_BITS-1] : 1'b0;
	assign trial     = {rem_q, shift_bit};
	assign fits      = trial >= {1'b0, period_q};
	assign next_rem  = fits ? STEP_BITS'(trial - {1'b0, period_q}) : trial[STEP_BITS-1:0];

	assign grown       = {{MULT_W{1'b0}}, period_q} * {{STEP_BITS{1'b0}}, mult_q};
	assign next_period = (grown > {{MULT_W{1'b0}}, STEP_MAX}) ? STEP_MAX
		: grown[STEP_BITS-1:0];

	assign product = {{(RATE_W-1){1'b0}}, diff_q} * {{RATE_W{1'b0}}, weight_q};

	assign stat.mult_is_one = mult_q == MULT_W'(1);
	assign stat.grow_more   = period_q <= left;
	assign rate             = rate_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			step_q   <= step_index;
			period_q <= (base_period == '0) ? STEP_BITS'(1) : base_period;
			mult_q   <= (period_multiplier == '0) ? MULT_W'(1) : period_multiplier;
			cum_q    <= '0;
			rem_q    <= '0;
			down_q   <= peak_rate < floor_rate;
			diff_q   <= (peak_rate < floor_rate) ? floor_rate - peak_rate
				: peak_rate - floor_rate;
		end
		if (cmd.mod_step) begin
			step_q <= {step_q[STEP_BITS-2:0], 1'b0};
		end
		if (cmd.mod_step || cmd.frac_step) begin
			rem_q  <= next_rem;
			quot_q <= {quot_q[IDX_W-2:0], fits};
		end
		if (cmd.grow_step) begin
			cum_q    <= cum_q + period_q;
			period_q <= next_period;
		end
		if (cmd.pos_load) begin
			rem_q <= left;
		end
		if (cmd.rom_read) begin
			weight_q <= weight_rom[quot_q];
		end
		if (cmd.mul) begin
			scaled_q <= product[FRAC_SHIFT +: RATE_W];
		end
		if (cmd.finish) begin
			rate_q <= down_q ? floor_rate - scaled_q : floor_rate + scaled_q;
		end
	end

endmodule

[sv/cwr_ctrl.sv]
// ----------------------------------------------------------------------------
// cwr_ctrl
// Sequencer for one word: period search or modulo, fraction divide, table
// read, scaling and output register handoff.
// ----------------------------------------------------------------------------
module cwr_ctrl
	import cwr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output cwr_cmd_t  cmd,
	input  cwr_stat_t stat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MOD,
		ST_GROW,
		ST_FRAC,
		ST_ROM,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.mod_step  = state_q == ST_MOD;
		cmd.grow_step = (state_q == ST_GROW) && stat.grow_more;
		cmd.pos_load  = (state_q == ST_GROW) && !stat.grow_more;
		cmd.frac_step = state_q == ST_FRAC;
		cmd.rom_read  = state_q == ST_ROM;
		cmd.mul       = state_q == ST_MUL;
		cmd.finish    = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (stat.mult_is_one) begin
						state_q <= ST_MOD;
						cnt_q   <= CNT_W'(STEP_BITS - 1);
					end else begin
						state_q <= ST_GROW;
					end
				end
				ST_MOD: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FRAC;
						cnt_q   <= CNT_W'(IDX_W - 1);
					end
				end
				ST_GROW: begin
					if (!stat.grow_more) begin
						state_q <= ST_FRAC;
						cnt_q   <= CNT_W'(IDX_W - 1);
					end
				end
				ST_FRAC: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_ROM;
					end
				end
				ST_ROM: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/cosine_warm_restart_lr.sv]
// ----------------------------------------------------------------------------
// cosine_warm_restart_lr
// Learning rate of the cosine annealing schedule with warm restarts.
// ----------------------------------------------------------------------------
// A step index word enters on in_valid/in_ready and one rate word leaves on
// out_valid/out_ready, unsigned Q4.28. The user must write the four schedule
// registers, through cfg_valid/cfg_ready with cfg_index and cfg_data, only
// while the block is idle; the block does not enforce this. cfg_ready is
// always high. One word is processed at a time. With a period multiplier of
// one the position is found by a restoring modulo. Otherwise the period
// search grows the period at most 32 times and then a final check loads
// the position. Both cases end with a fraction divide through the same
// divide step, which yields the table index, a registered weight table
// read and a registered multiply.
// in_ready is high only while no word is in progress, and a finished rate
// waits in the output register, so the next word may be taken while it is
// held. A stalled receiver holds the block only once a second rate is ready.
// Reset clears the sequencer and the output valid flag and returns the
// registers to period 1000, multiplier 1, peak 0.1 and floor 0.
// ----------------------------------------------------------------------------
module cosine_warm_restart_lr
	import cwr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [STEP_BITS-1:0] step_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RATE_W-1:0]    rate,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RATE_W-1:0]    cfg_data
);

	logic [STEP_BITS-1:0] base_period_q;
	logic [MULT_W-1:0]    period_multiplier_q;
	logic [RATE_W-1:0]    peak_rate_q;
	logic [RATE_W-1:0]    floor_rate_q;
	cwr_cmd_t             cmd;
	cwr_stat_t            stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_period_q       <= BASE_PERIOD_RESET;
			period_multiplier_q <= PERIOD_MULTIPLIER_RESET;
			peak_rate_q         <= PEAK_RATE_RESET;
			floor_rate_q        <= FLOOR_RATE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BASE_PERIOD: begin
					base_period_q <= cfg_data;
				end
				REG_PERIOD_MULTIPLIER: begin
					period_multiplier_q <= cfg_data[MULT_W-1:0];
				end
				REG_PEAK_RATE: begin
					peak_rate_q <= cfg_data;
				end
				REG_FLOOR_RATE: begin
					floor_rate_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	cwr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	cwr_datapath u_datapath (
		.clk               (clk),
		.cmd               (cmd),
		.stat              (stat),
		.step_index        (step_index),
		.base_period       (base_period_q),
		.period_multiplier (period_multiplier_q),
		.peak_rate         (peak_rate_q),
		.floor_rate        (floor_rate_q),
		.rate              (rate)
	);

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the warm-restart cosine learning-rate block.
// A short table of directed words (reset schedule, zero and full-range
// periods, zero and maximum multipliers, peak below floor, saturated
// period growth) is followed by randomized schedule settings with random
// step words. Every rate word is checked against a bench-side model of the
// schedule or a known value from the table, while both handshakes idle at
// random and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb
	import cwr_pkg::*;
();

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASES       = 11;
	localparam int PHASE_WORDS  = 150;
	localparam int IDLE_PCT     = 38;
	localparam int CALM_FIRST   = 700;
	localparam int CALM_LAST    = 900;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 60;
	localparam int REPORT_MAX   = 10;

	typedef enum logic [1:0] {ROW_CFG, ROW_STEP, ROW_KNOWN} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_sel;
		logic [STEP_BITS-1:0]  value;
		logic [RATE_W-1:0]     known;
	} plan_row_t;

	localparam int PLAN_LEN = 39;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ROW_KNOWN, '0, 32'd0, PEAK_RATE_RESET},
		'{ROW_KNOWN, '0, 32'd1000, PEAK_RATE_RESET},
		'{ROW_STEP, '0, 32'd500, '0},
		'{ROW_STEP, '0, 32'd999, '0},
		'{ROW_STEP, '0, 32'hFFFF_FFFF, '0},
		'{ROW_CFG, REG_BASE_PERIOD, 32'd0, '0},
		'{ROW_KNOWN, '0, 32'hFFFF_FFFF, PEAK_RATE_RESET},
		'{ROW_KNOWN, '0, 32'd12345, PEAK_RATE_RESET},
		'{ROW_CFG, REG_BASE_PERIOD, 32'hFFFF_FFFF, '0},
		'{ROW_STEP, '0, 32'hFFFF_FFFE, '0},
		'{ROW_KNOWN, '0, 32'hFFFF_FFFF, PEAK_RATE_RESET},
		'{ROW_CFG, REG_BASE_PERIOD, 32'd1024, '0},
		'{ROW_CFG, REG_PEAK_RATE, 32'hFFFF_FFFF, '0},
		'{ROW_KNOWN, '0, 32'd0, 32'hFFFF_FFFF},
		'{ROW_STEP, '0, 32'd1023, '0},
		'{ROW_STEP, '0, 32'd2047, '0},
		'{ROW_CFG, REG_PEAK_RATE, 32'd0, '0},
		'{ROW_CFG, REG_FLOOR_RATE, 32'hFFFF_FFFF, '0},
		'{ROW_KNOWN, '0, 32'd0, 32'd0},
		'{ROW_STEP, '0, 32'd512, '0},
		'{ROW_CFG, REG_PERIOD_MULTIPLIER, 32'd0, '0},
		'{ROW_CFG, REG_BASE_PERIOD, 32'd10, '0},
		'{ROW_STEP, '0, 32'd25, '0},
		'{ROW_CFG, REG_PERIOD_MULTIPLIER, 32'd2, '0},
		'{ROW_CFG, REG_BASE_PERIOD, 32'd1, '0},
		'{ROW_KNOWN, '0, 32'd3, 32'd0},
		'{ROW_STEP, '0, 32'hFFFF_FFFF, '0},
		'{ROW_CFG, REG_PERIOD_MULTIPLIER, 32'd31, '0},
		'{ROW_CFG, REG_PEAK_RATE, 32'h8000_0000, '0},
		'{ROW_CFG, REG_FLOOR_RATE, 32'h1000_0000, '0},
		'{ROW_KNOWN, '0, 32'd0, 32'h8000_0000},
		'{ROW_STEP, '0, 32'hFFFF_FFFF, '0},
		'{ROW_CFG, REG_PERIOD_MULTIPLIER, 32'd16, '0},
		'{ROW_CFG, REG_BASE_PERIOD, 32'hFFFF_FFFF, '0},
		'{ROW_KNOWN, '0, 32'hFFFF_FFFF, 32'h8000_0000},
		'{ROW_STEP, '0, 32'hFFFF_FFFE, '0},
		'{ROW_CFG, REG_PEAK_RATE, 32'h1234_5678, '0},
		'{ROW_CFG, REG_FLOOR_RATE, 32'h1234_5678, '0},
		'{ROW_KNOWN, '0, 32'd7, 32'h1234_5678}
	};

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [STEP_BITS-1:0] step_index = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [RATE_W-1:0]    rate;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [RATE_W-1:0]    cfg_data   = '0;

	logic [STEP_BITS-1:0] sched_period = BASE_PERIOD_RESET;
	logic [MULT_W-1:0]    sched_mult   = PERIOD_MULTIPLIER_RESET;
	logic [RATE_W-1:0]    sched_peak   = PEAK_RATE_RESET;
	logic [RATE_W-1:0]    sched_floor  = FLOOR_RATE_RESET;

	logic [RATE_W-1:0] rate_due [$];
	logic [RATE_W-1:0] rate_want;
	int                mismatch_count = 0;
	int                words_sent     = 0;
	int                rates_seen     = 0;
	int                hold_left      = 0;
	int                cycle_count    = 0;

	cosine_warm_restart_lr uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.step_index (step_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rate       (rate),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Table weight (1 + cos(pi * slot / depth)) / 2 in Q1.30, built as the
	// square of a truncated Taylor cosine of half the angle.
	function automatic longint unsigned cos_weight(input longint unsigned slot);
		longint unsigned taylor_div [6] = '{182, 132, 90, 56, 30, 12};
		longint unsigned angle;
		longint unsigned sq;
		longint unsigned acc;
		longint unsigned half;
		longint unsigned c;
		angle = (HALF_PI_Q30 * slot) / COS_TABLE_DEPTH;
		sq = (angle * angle) >> FRAC_SHIFT;
		acc = Q30_ONE;
		foreach (taylor_div[k])
			acc = Q30_ONE - (((sq * acc) >> FRAC_SHIFT) / taylor_div[k]);
		half = (sq * acc) >> (FRAC_SHIFT + 1);
		c = (half >= Q30_ONE) ? 64'd0 : Q30_ONE - half;
		return (c * c) >> FRAC_SHIFT;
	endfunction

	function automatic logic [RATE_W-1:0] predict_rate(input logic [STEP_BITS-1:0] step);
		longint unsigned span_max;
		longint unsigned period;
		longint unsigned growth;
		longint unsigned start;
		longint unsigned pos;
		longint unsigned slot;
		longint unsigned w;
		longint unsigned diff;
		span_max = STEP_MAX;
		period = sched_period;
		growth = sched_mult;
		if (period == 0)
			period = 1;
		if (period > span_max)
			period = span_max;
		if (growth == 0)
			growth = 1;
		if (growth == 1) begin
			pos = step % period;
		end else begin
			start = 0;
			while (period <= step - start) begin
				start += period;
				if (period > span_max / growth)
					period = span_max;
				else
					period *= growth;
			end
			pos = step - start;
		end
		slot = (pos * COS_TABLE_DEPTH) / period;
		if (slot >= COS_TABLE_DEPTH)
			slot = COS_TABLE_DEPTH - 1;
		w = cos_weight(slot);
		if (sched_peak >= sched_floor) begin
			diff = sched_peak - sched_floor;
			return RATE_W'(sched_floor + ((diff * w) >> FRAC_SHIFT));
		end else begin
			diff = sched_floor - sched_peak;
			return RATE_W'(sched_floor - ((diff * w) >> FRAC_SHIFT));
		end
	endfunction

	task automatic flag_rate(input string what, input logic [RATE_W-1:0] want,
			input logic [RATE_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("mismatch: %s rate expected %h got %h", what, want, got);
	endtask

	task automatic send_step(input logic [STEP_BITS-1:0] s, input bit fixed,
			input logic [RATE_W-1:0] fixed_rate);
		while (!(words_sent >= CALM_FIRST && words_sent < CALM_LAST) &&
				$urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		step_index <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		rate_due.push_back(fixed ? fixed_rate : predict_rate(s));
		words_sent++;
	endtask

	task automatic drain_rates();
		in_valid <= 1'b0;
		while (rate_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [RATE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (sel)
			REG_BASE_PERIOD:       sched_period = data;
			REG_PERIOD_MULTIPLIER: sched_mult = data[MULT_W-1:0];
			REG_PEAK_RATE:         sched_peak = data;
			REG_FLOOR_RATE:        sched_floor = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [RATE_W-1:0] pick_rate_level();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_schedule();
		logic [RATE_W-1:0] base;
		logic [RATE_W-1:0] mult_word;
		case ($urandom_range(7))
			0:       base = 0;
			1:       base = 1;
			2:       base = $urandom_range(16, 2);
			3:       base = $urandom_range(2000, 17);
			4:       base = '1;
			5:       base = $urandom;
			default: base = $urandom_range(100000, 100);
		endcase
		mult_word = $urandom;
		case ($urandom_range(5))
			0, 1:    mult_word[MULT_W-1:0] = MULT_W'(1);
			2, 3:    mult_word[MULT_W-1:0] = MULT_W'($urandom_range(16, 2));
			4:       mult_word[MULT_W-1:0] = MULT_W'(0);
			default: mult_word[MULT_W-1:0] = MULT_W'($urandom_range(31, 17));
		endcase
		write_reg(REG_BASE_PERIOD, base);
		write_reg(REG_PERIOD_MULTIPLIER, mult_word);
		write_reg(REG_PEAK_RATE, pick_rate_level());
		write_reg(REG_FLOOR_RATE, pick_rate_level());
	endtask

	function automatic logic [STEP_BITS-1:0] pick_step();
		case ($urandom_range(5))
			0, 1:    return $urandom;
			2:       return $urandom_range(20000, 0);
			3:       return sched_period + $urandom_range(2, 0) - 1;
			4:       return $urandom_range(1, 0) ? STEP_MAX : '0;
			default: return $urandom & (STEP_MAX >> $urandom_range(31, 0));
		endcase
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (rate_due.size() == 0) begin
				flag_rate("unexpected", '0, rate);
			end else begin
				rate_want = rate_due.pop_front();
				if (rate !== rate_want)
					flag_rate("wrong", rate_want, rate);
			end
			rates_seen++;
			if (rates_seen == HOLD_AT)
				hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rates_seen >= CALM_FIRST && rates_seen < CALM_LAST) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int r = 0; r < PLAN_LEN; r++) begin
			case (PLAN[r].kind)
				ROW_CFG: begin
					drain_rates();
					write_reg(PLAN[r].reg_sel, PLAN[r].value);
				end
				ROW_KNOWN: send_step(PLAN[r].value, 1'b1, PLAN[r].known);
				default:   send_step(PLAN[r].value, 1'b0, '0);
			endcase
		end
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_rates();
			random_schedule();
			for (int n = 0; n < PHASE_WORDS; n++)
				send_step(pick_step(), 1'b0, '0);
		end
		drain_rates();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && rate_due.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
